/* hw/rtl/sabs_pkg.sv */
// Shared constants, codes and status types of the sorted array binary search block.
package sabs_pkg;

  localparam int DEFAULT_STORE_DEPTH = 1024;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // Fixed widths of the item fields on the channels.
  localparam int INDEX_W = 10;
  localparam int FIELD_W = 32;

  // Item kinds on the input channel.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Operation codes carried through the queue.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } sabs_q_status_t;

  typedef struct packed {
    logic busy;
  } sabs_back_status_t;

endpackage

/* hw/rtl/sabs_stream_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface sabs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic        [sabs_pkg::INDEX_W-1:0] entry_index;
  logic signed [sabs_pkg::FIELD_W-1:0] entry_value;
  logic        [sabs_pkg::INDEX_W-1:0] range_low;
  logic        [sabs_pkg::INDEX_W-1:0] range_high;
  logic signed [sabs_pkg::FIELD_W-1:0] search_key;

  modport source (
    output valid, kind, entry_index, entry_value, range_low, range_high, search_key,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, entry_value, range_low, range_high, search_key,
    output ready
  );
endinterface

interface sabs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [sabs_pkg::INDEX_W-1:0] match_index;

  modport source (
    output valid, found, match_index,
    input  ready
  );
  modport sink (
    input  valid, found, match_index,
    output ready
  );
endinterface

/* hw/rtl/sorted_array_binary_search_core.sv */
// A write is held in the queue once accepted and reaches the store as it leaves the queue,
// which waits while the search engine is busy. A query runs each probe through S_CHECK
// and S_CMP, up to log2(STORE_DEPTH)+1 probes, then S_DONE hands the result to the output register.
// The single store read port serves one probe at a time, and the back end takes no new item until
// the last query has handed on its result. Reset clears the queue, the search controller and the
// output register; store contents are undefined until written and get no clearing pass.
module sorted_array_binary_search_core #(
  parameter int STORE_DEPTH = sabs_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_WIDTH = sabs_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  sabs_in_if.sink    req,
  sabs_out_if.source rsp
);
  import sabs_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int AW    = (IDX_W + 1 > INDEX_W) ? IDX_W + 1 : INDEX_W;
  localparam int EW    = 2 + IDX_W + VALUE_WIDTH + 2 * AW;

  logic              push;
  logic [EW-1:0]     push_data;
  logic              pop;
  logic [EW-1:0]     pop_data;
  sabs_q_status_t    q_status;
  sabs_back_status_t back_status;

  sabs_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .AW          (AW),
    .EW          (EW)
  ) u_front (
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  sabs_queue #(
    .EW (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  sabs_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .AW          (AW),
    .EW          (EW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .status   (back_status),
    .rsp      (rsp)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("push into full queue");

  a_pop_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!q_status.empty && !back_status.busy))
    else $error("pop while queue empty or search busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(back_status.busy))
    else $error("result without a finished query");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.match_index == '0))
    else $error("miss with nonzero index");

  a_hit_in_store: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (32'(rsp.match_index) < 32'(STORE_DEPTH)))
    else $error("hit index beyond store");

endmodule

/* hw/rtl/sabs_front.sv */
// Front end: accepts items, classifies them and packs queue entries.
module sabs_front #(
  parameter int STORE_DEPTH = sabs_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_WIDTH = sabs_pkg::DEFAULT_VALUE_WIDTH,
  parameter int IDX_W       = $clog2(STORE_DEPTH),
  parameter int AW          = (IDX_W + 1 > sabs_pkg::INDEX_W) ? IDX_W + 1 : sabs_pkg::INDEX_W,
  parameter int EW          = 2 + IDX_W + VALUE_WIDTH + 2 * AW
) (
  sabs_in_if.sink                 req,
  input  sabs_pkg::sabs_q_status_t q_status,
  output logic                    push,
  output logic [EW-1:0]           push_data
);
  import sabs_pkg::*;

  logic [1:0]             op;
  logic [AW-1:0]          idx_ext;
  logic [AW-1:0]          lo_ext;
  logic [AW-1:0]          hi_ext;
  logic [AW-1:0]          hi_clamp;
  logic [VALUE_WIDTH-1:0] value;
  logic                   accept;
  logic                   drop;

  assign req.ready = !q_status.full;
  assign accept    = req.valid && req.ready;

  always_comb begin
    idx_ext  = AW'(req.entry_index);
    lo_ext   = AW'(req.range_low);
    hi_ext   = AW'(req.range_high);
    // Clamp the top of the range to the last store entry.
    hi_clamp = (hi_ext > AW'(STORE_DEPTH - 1)) ? AW'(STORE_DEPTH - 1) : hi_ext;
    drop     = 1'b0;
    if (req.kind == KIND_WRITE) begin
      op    = OP_WRITE;
      value = VALUE_WIDTH'(req.entry_value);
      // Drop writes beyond the store.
      drop  = (idx_ext >= AW'(STORE_DEPTH));
    end else begin
      value = VALUE_WIDTH'(req.search_key);
      op    = (lo_ext > hi_clamp) ? OP_EMPTY : OP_QUERY;
    end
  end

  assign push      = accept && !drop;
  assign push_data = {op, IDX_W'(req.entry_index), value, lo_ext, hi_clamp};

endmodule

/* hw/rtl/sabs_queue.sv */
// Two-entry queue between the front end and the search engine.
module sabs_queue #(
  parameter int EW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [EW-1:0]            push_data,
  input  logic                     pop,
  output logic [EW-1:0]            pop_data,
  output sabs_pkg::sabs_q_status_t status
);
  import sabs_pkg::*;

  logic [EW-1:0] slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign do_push      = push && (count != 2'd2);
  assign do_pop       = pop && (count != 2'd0);
  assign pop_data     = slots[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* hw/rtl/sabs_back.sv */
// Back end: holds the store, runs writes and the halving search, registers results.
module sabs_back #(
  parameter int STORE_DEPTH = sabs_pkg::DEFAULT_STORE_DEPTH,
  parameter int VALUE_WIDTH = sabs_pkg::DEFAULT_VALUE_WIDTH,
  parameter int IDX_W       = $clog2(STORE_DEPTH),
  parameter int AW          = (IDX_W + 1 > sabs_pkg::INDEX_W) ? IDX_W + 1 : sabs_pkg::INDEX_W,
  parameter int EW          = 2 + IDX_W + VALUE_WIDTH + 2 * AW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sabs_pkg::sabs_q_status_t    q_status,
  input  logic [EW-1:0]               q_data,
  output logic                        pop,
  output sabs_pkg::sabs_back_status_t status,
  sabs_out_if.source                  rsp
);
  import sabs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [VALUE_WIDTH-1:0] store [STORE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]       rd_addr;
  logic                   we;

  logic [1:0]             q_op;
  logic [IDX_W-1:0]       q_addr;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [AW-1:0]          q_lo;
  logic [AW-1:0]          q_hi;

  logic [1:0]                   state, state_next;
  logic signed [AW:0]           lo, lo_next;
  logic signed [AW:0]           hi, hi_next;
  logic [IDX_W-1:0]             mid, mid_next;
  logic [VALUE_WIDTH-1:0]       key, key_next;
  logic                         res_found, res_found_next;
  logic [INDEX_W-1:0]           res_index, res_index_next;
  logic                         out_valid, out_valid_next;
  logic                         out_found, out_found_next;
  logic [INDEX_W-1:0]           out_index, out_index_next;
  logic [AW:0]                  sum;
  logic [IDX_W-1:0]             mid_calc;

  assign {q_op, q_addr, q_value, q_lo, q_hi} = q_data;

  // Bounds are non-negative whenever a probe is issued.
  assign sum      = (AW + 1)'(lo[AW-1:0]) + (AW + 1)'(hi[AW-1:0]);
  assign mid_calc = IDX_W'(sum >> 1);

  always_ff @(posedge clk) begin
    if (we) begin
      store[q_addr] <= q_value;
    end
    rd_data <= store[rd_addr];
  end

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    res_found_next = res_found;
    res_index_next = res_index;
    out_found_next = out_found;
    out_index_next = out_index;
    out_valid_next = out_valid && !rsp.ready;
    pop            = 1'b0;
    we             = 1'b0;
    rd_addr        = mid;
    case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (q_op)
            OP_WRITE: begin
              we = 1'b1;
            end
            OP_QUERY: begin
              lo_next    = {1'b0, q_lo};
              hi_next    = {1'b0, q_hi};
              key_next   = q_value;
              state_next = S_CHECK;
            end
            default: begin
              res_found_next = 1'b0;
              res_index_next = '0;
              state_next     = S_DONE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (lo > hi) begin
          res_found_next = 1'b0;
          res_index_next = '0;
          state_next     = S_DONE;
        end else begin
          mid_next   = mid_calc;
          rd_addr    = mid_calc;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data == key) begin
          res_found_next = 1'b1;
          res_index_next = INDEX_W'(mid);
          state_next     = S_DONE;
        end else if ($signed(rd_data) < $signed(key)) begin
          lo_next    = (AW + 1)'(mid) + (AW + 1)'(1);
          state_next = S_CHECK;
        end else begin
          hi_next    = (AW + 1)'(mid) - (AW + 1)'(1);
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_found_next = res_found;
          out_index_next = res_index;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lo        <= '0;
      hi        <= '0;
      key       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      lo        <= lo_next;
      hi        <= hi_next;
      key       <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    mid       <= mid_next;
    res_found <= res_found_next;
    res_index <= res_index_next;
    out_found <= out_found_next;
    out_index <= out_index_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.match_index = out_index;

  assign status.busy = (state != S_IDLE);

endmodule

/* dv/sorted_array_binary_search_core_tb.sv */
// Self-checking testbench for the sorted array binary search core.
module sorted_array_binary_search_core_tb;
  import sabs_pkg::*;

  localparam int STORE_DEPTH = DEFAULT_STORE_DEPTH;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    logic                      kind;
    logic        [INDEX_W-1:0] entry_index;
    logic signed [FIELD_W-1:0] entry_value;
    logic        [INDEX_W-1:0] range_low;
    logic        [INDEX_W-1:0] range_high;
    logic signed [FIELD_W-1:0] search_key;
  } search_item_t;

  typedef struct {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } search_result_t;

  logic clk = 1'b0;
  logic rst;

  sabs_in_if  req ();
  sabs_out_if rsp ();

  sorted_array_binary_search_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #4 clk = ~clk;

  // Shadow copy of the store and the queries still waiting for their answer.
  logic signed [FIELD_W-1:0] shadow_store [STORE_DEPTH];
  bit                        written [STORE_DEPTH];
  search_result_t            pending_answers [$];
  search_result_t            next_answer;

  int errors;
  int items_sent;
  int idle_cycles;
  bit src_idle_on;
  bit sink_idle_on;
  int hold_cycles_req;
  int hold_left;
  int stall_left;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one accepted item to the shadow store and queue the answer a query must give.
  function automatic void predict_search(search_item_t it);
    search_result_t r;
    int lo;
    int hi;
    int mid;
    if (it.kind == KIND_WRITE) begin
      shadow_store[it.entry_index] = it.entry_value;
      return;
    end
    r.found = 1'b0;
    r.match_index = '0;
    lo = it.range_low;
    hi = it.range_high;
    if (hi > STORE_DEPTH - 1) hi = STORE_DEPTH - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_store[mid] == it.search_key) begin
        r.found = 1'b1;
        r.match_index = INDEX_W'(mid);
        lo = hi + 1;
      end else if (shadow_store[mid] < it.search_key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    pending_answers.push_back(r);
  endfunction

  task automatic send_item(search_item_t it);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= it.kind;
    req.entry_index <= it.entry_index;
    req.entry_value <= it.entry_value;
    req.range_low   <= it.range_low;
    req.range_high  <= it.range_high;
    req.search_key  <= it.search_key;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_search(it);
    items_sent++;
  endtask

  // Unused fields of each kind carry random junk the block must ignore.
  task automatic send_write(int idx, logic signed [FIELD_W-1:0] val);
    search_item_t it;
    it.kind        = KIND_WRITE;
    it.entry_index = INDEX_W'(idx);
    it.entry_value = val;
    it.range_low   = INDEX_W'($urandom);
    it.range_high  = INDEX_W'($urandom);
    it.search_key  = $urandom;
    written[idx] = 1'b1;
    send_item(it);
  endtask

  task automatic send_query(int lo, int hi, logic signed [FIELD_W-1:0] key);
    search_item_t it;
    it.kind        = KIND_QUERY;
    it.entry_index = INDEX_W'($urandom);
    it.entry_value = $urandom;
    it.range_low   = INDEX_W'(lo);
    it.range_high  = INDEX_W'(hi);
    it.search_key  = key;
    send_item(it);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value(int vmode);
    int r;
    r = $urandom_range(0, 20);
    case (vmode)
      0: return $urandom_range(0, 100) - 50;
      3: return $urandom_range(0, 1) ? (32'sh8000_0000 + r) : (32'sh7FFF_FFFF - r);
      default: return $urandom;
    endcase
  endfunction

  // Load [base, base+len-1]; mostly ascending data, now and then unsorted.
  task automatic load_segment(int base, int len);
    logic signed [FIELD_W-1:0] vals [$];
    int vmode;
    int i;
    vmode = $urandom_range(0, 3);
    for (i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) vals.push_back(vals[i-1]);
      else vals.push_back(pick_value(vmode));
    end
    if ($urandom_range(0, 9) != 0) vals.sort();
    if ($urandom_range(0, 1) == 0) begin
      for (i = 0; i < len; i++) send_write(base + i, vals[i]);
    end else begin
      for (i = len - 1; i >= 0; i--) send_write(base + i, vals[i]);
    end
  endtask

  // Query a sub-range of [a, b]; every entry there must already be written.
  task automatic query_in_span(int a, int b);
    int lo;
    int hi;
    int sel;
    logic signed [FIELD_W-1:0] key;
    if ($urandom_range(0, 2) == 0) begin
      lo = a;
      hi = b;
    end else begin
      lo = $urandom_range(a, b);
      hi = $urandom_range(lo, b);
    end
    key = shadow_store[$urandom_range(lo, hi)];
    sel = $urandom_range(0, 7);
    case (sel)
      4: key = key + 1;
      5: key = key - 1;
      6: key = $urandom;
      7: key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      default: ;
    endcase
    send_query(lo, hi, key);
  endtask

  task automatic query_reversed();
    int lo;
    lo = $urandom_range(1, STORE_DEPTH - 1);
    send_query(lo, $urandom_range(0, lo - 1), $urandom);
  endtask

  task automatic test_directed();
    logic signed [FIELD_W-1:0] ramp [10];
    int i;
    ramp = '{32'sh8000_0000, -1000, -1000, -1, 0, 1, 5, 5, 1000, 32'sh7FFF_FFFF};
    for (i = 0; i < 10; i++) send_write(i, ramp[i]);
    send_write(STORE_DEPTH - 1, 32'sh7FFF_FFFF);
    send_query(0, 9, 32'sh8000_0000);
    send_query(0, 9, 32'sh7FFF_FFFF);
    send_query(0, 9, 0);
    // duplicates: index is whichever equal entry the halving hits first
    send_query(0, 9, 5);
    send_query(0, 9, -1000);
    send_query(0, 9, 3);
    send_query(0, 3, 2);
    send_query(4, 4, 0);
    send_query(4, 4, 1);
    send_query(STORE_DEPTH - 1, STORE_DEPTH - 1, 32'sh7FFF_FFFF);
    send_query(STORE_DEPTH - 1, STORE_DEPTH - 1, 0);
    send_query(STORE_DEPTH - 1, 0, 32'sh7FFF_FFFF);
    send_query(5, 4, 0);
  endtask

  // Stall the result side long enough that the input side backs up.
  task automatic test_output_backpressure();
    int i;
    load_segment(200, 64);
    src_idle_on = 1'b0;
    hold_cycles_req = 300;
    for (i = 0; i < 40; i++) query_in_span(200, 263);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_segments();
    int stop_at;
    int base;
    int len;
    int nq;
    int r;
    int p;
    int a;
    int b;
    int i;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      src_idle_on  = $urandom_range(0, 4) != 0;
      sink_idle_on = $urandom_range(0, 4) != 0;
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 32);
      else if (r < 97) len = $urandom_range(33, 200);
      else len = $urandom_range(201, 512);
      base = $urandom_range(0, STORE_DEPTH - 1);
      if (base + len > STORE_DEPTH) len = STORE_DEPTH - base;
      load_segment(base, len);
      // stray writes may break the order of neighboring data
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_write($urandom_range(0, STORE_DEPTH - 1), $urandom);
      end
      nq = $urandom_range(1, 12);
      for (i = 0; i < nq; i++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          query_in_span(base, base + len - 1);
        end else if (r < 9) begin
          // widen to the whole written run around a point of this segment
          p = $urandom_range(base, base + len - 1);
          a = p;
          b = p;
          while (a > 0 && written[a-1]) a--;
          while (b < STORE_DEPTH - 1 && written[b+1]) b++;
          query_in_span(a, b);
        end else begin
          query_reversed();
        end
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Result side: random stalls plus the long hold the pressure test asks for.
  always @(negedge clk) begin
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = sink_idle_on ? pick_gap() : 0;
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0b match_index=%0d",
                 $time, rsp.found, rsp.match_index);
        errors++;
      end else begin
        next_answer = pending_answers.pop_front();
        if (rsp.found !== next_answer.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, next_answer.found, rsp.found);
          errors++;
        end
        if (rsp.match_index !== next_answer.match_index) begin
          $display("%0t: match_index mismatch: expected %0d, actual %0d",
                   $time, next_answer.match_index, rsp.match_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.kind        = KIND_WRITE;
    req.entry_index = '0;
    req.entry_value = '0;
    req.range_low   = '0;
    req.range_high  = '0;
    req.search_key  = '0;
    rsp.ready       = 1'b0;
    errors          = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    hold_cycles_req = 0;
    hold_left       = 0;
    stall_left      = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      shadow_store[i] = '0;
      written[i]      = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_output_backpressure();
    test_random_segments();

    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sorted_array_binary_search_core.f */
hw/rtl/sabs_pkg.sv
hw/rtl/sabs_stream_if.sv
hw/rtl/sabs_front.sv
hw/rtl/sabs_queue.sv
hw/rtl/sabs_back.sv
hw/rtl/sorted_array_binary_search_core.sv
dv/sorted_array_binary_search_core_tb.sv
